@@ hdl/lfu_pkg.sv @@
// Shared types and constants for the LFU cache table.
// Payload structs, memory entry layout, controller commands and states.
// No dependencies.
package lfu_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned StampW = 48;
  localparam int unsigned CapW   = 7;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CapW-1:0]   CapReset = 7'd64;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                    command;
    logic [KeyW-1:0]         key;
    logic signed [DataW-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic signed [DataW-1:0] read_value;
  } out_t;

  // One table entry; stamp orders entries by last touch (larger is newer)
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;    // capture the input transfer, reset scan trackers
    logic clr_wr;  // clear the entry at the sweep address
    logic rd_en;   // read the entry at the sweep address
    logic commit;  // apply the operation and post the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register holds a result that is not taken
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_e;

endpackage

@@ hdl/lfu_cache_table.sv @@
// Top level of the LFU cache table with LRU tie-break.
// Instantiates lfu_ctrl and lfu_dp; depends on lfu_pkg.
//
//  channel | signals                         | moves
//  --------+---------------------------------+------------------------------
//  in      | in_valid_i, in_stall_o, in_data_i  | command, key, value
//  out     | out_valid_o, out_stall_i, out_data_o | found, read_value
//  cfg     | cfg_we_i, cfg_wdata_i           | capacity_in_use
//
// Each transfer passes through the accepting idle state, a scan that reads the
// entry memory once per entry, a drain state and an update state.
// After reset a clearing sweep over every entry holds in_stall_o high.
// The update waits while a previous result is stalled at the output.
module lfu_cache_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lfu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lfu_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i
);
  import lfu_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ctrl_cmd_t       cmd;
  dp_stat_t        stat;
  logic [IdxW-1:0] addr;
  state_e          state;

  lfu_ctrl #(
    .CAPACITY (CAPACITY),
    .IdxW     (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .state_o    (state)
  );

  lfu_dp #(
    .CAPACITY (CAPACITY),
    .IdxW     (IdxW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // One operation at a time: an accepted transfer blocks the next
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A commit only happens in the update state with the result slot free
  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (state == ST_UPDATE && !stat.out_busy))
    else $error("commit outside update or onto a stalled result");

  // Memory is never read and cleared or committed in the same cycle
  a_rd_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd_en && (cmd.clr_wr || cmd.commit)))
    else $error("memory access conflict");
`endif

endmodule

@@ hdl/lfu_ctrl.sv @@
// Controller for the LFU cache table: clearing sweep, scan sequencing, commit.
// Depends on lfu_pkg.
module lfu_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IdxW     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lfu_pkg::dp_stat_t    stat_i,
  output lfu_pkg::ctrl_cmd_t   cmd_o,
  output logic [IdxW-1:0]      addr_o,
  output lfu_pkg::state_e      state_o
);
  import lfu_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept  = (state_q == ST_IDLE) && in_valid_i;
  assign addr_o  = cnt_q;
  assign state_o = state_q;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = accept;
      end
      ST_SCAN:   cmd_o.rd_en  = 1'b1;
      ST_LAST:   cmd_o        = '0;
      ST_UPDATE: cmd_o.commit = !stat_i.out_busy;
      default:   cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/lfu_dp.sv @@
// Datapath for the LFU cache table: entry memory, scan compare, update, result.
// Depends on lfu_pkg.
module lfu_dp #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IdxW     = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfu_pkg::in_t        in_data_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  lfu_pkg::ctrl_cmd_t  cmd_i,
  input  logic [IdxW-1:0]     addr_i,
  output lfu_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lfu_pkg::out_t       out_data_o
);
  import lfu_pkg::*;

  localparam int unsigned OccW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (OccW > CapW) ? OccW : CapW;
  localparam logic [CmpW-1:0] CapMax = CmpW'(CAPACITY);

  entry_t mem [CAPACITY];
  entry_t rd_q;

  in_t             op_q;
  logic [CapW-1:0] cap_q;
  logic [OccW-1:0] occ_q;
  logic [StampW-1:0] stamp_q;

  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;

  logic            hit_q, vic_q;
  logic [IdxW-1:0] hit_idx_q, vic_idx_q;
  entry_t          hit_ent_q, vic_ent_q;

  logic            out_valid_q;
  out_t            out_q;

  // Commit decode
  logic [CmpW-1:0] cap_eff, occ_ext;
  logic            do_write, do_insert, evict;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_ent;
  logic [CountW-1:0] cnt_inc;

  assign cap_eff = (CmpW'(cap_q) > CapMax) ? CapMax : CmpW'(cap_q);
  assign occ_ext = CmpW'(occ_q);
  assign evict   = occ_ext >= cap_eff;
  assign cnt_inc = (hit_ent_q.count == CountMax) ? CountMax : hit_ent_q.count + 1'b1;

  always_comb begin
    do_write  = 1'b0;
    do_insert = 1'b0;
    wr_idx    = hit_idx_q;
    wr_ent    = hit_ent_q;
    if (hit_q) begin
      do_write     = 1'b1;
      wr_ent.count = cnt_inc;
      wr_ent.stamp = stamp_q;
      if (op_q.command == CMD_PUT) begin
        wr_ent.data = op_q.value;
      end
    end else if (op_q.command == CMD_PUT && cap_eff != '0) begin
      // Entry position is never visible, so a victim's slot takes the new key
      if (evict) begin
        do_write = vic_q;
        wr_idx   = vic_idx_q;
      end else begin
        do_write  = 1'b1;
        do_insert = 1'b1;
        wr_idx    = hit_idx_q;
      end
      wr_ent.valid = 1'b1;
      wr_ent.key   = op_q.key;
      wr_ent.data  = op_q.value;
      wr_ent.count = CountW'(1);
      wr_ent.stamp = stamp_q;
    end
  end

  // First free slot seen during the scan takes an insert
  logic            free_q;
  logic [IdxW-1:0] free_idx_q;
  logic [IdxW-1:0] ins_idx;
  assign ins_idx = free_idx_q;

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[addr_i] <= '0;
    end else if (cmd_i.commit && do_write && (!do_insert || free_q)) begin
      mem[do_insert ? ins_idx : wr_idx] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr_i];
    end
  end

  // Operand capture and scan compare
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_data_i;
    end
    cmp_idx_q <= addr_i;
    if (cmp_vld_q) begin
      if (rd_q.valid && rd_q.key == op_q.key && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
        hit_ent_q <= rd_q;
      end
      if (rd_q.valid && (!vic_q || rd_q.count < vic_ent_q.count ||
          (rd_q.count == vic_ent_q.count && rd_q.stamp < vic_ent_q.stamp))) begin
        vic_idx_q <= cmp_idx_q;
        vic_ent_q <= rd_q;
      end
      if (!rd_q.valid && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  // Control flags, occupancy, stamp, config, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      vic_q       <= 1'b0;
      free_q      <= 1'b0;
      occ_q       <= '0;
      stamp_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        vic_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (rd_q.valid && rd_q.key == op_q.key) begin
          hit_q <= 1'b1;
        end
        if (rd_q.valid) begin
          vic_q <= 1'b1;
        end
        if (!rd_q.valid) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (do_write) begin
          stamp_q <= stamp_q + 1'b1;
        end
        if (do_insert && free_q) begin
          occ_q <= occ_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.found      <= hit_q;
      out_q.read_value <= (hit_q && op_q.command == CMD_GET) ? hit_ent_q.data : '0;
    end
  end

  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

@@ tb/tb_lfu_cache_table.sv @@
// Testbench for lfu_cache_table: directed and random get/put traffic with
// a class-based LFU/LRU predictor and an in-order result checker.
// Depends on lfu_pkg and the lfu_cache_table RTL.
module tb_lfu_cache_table;
  import lfu_pkg::*;

  localparam int Cap = 64;
  localparam int CycleLimit = 400000;

  // Predictor of the table plus the queue of pending results
  class lfu_scoreboard;
    bit          valid_q[Cap];
    logic [31:0] key_q[Cap];
    logic [31:0] data_q[Cap];
    logic [15:0] count_q[Cap];
    int          rank_q[Cap];
    int          occupied;
    int          capacity;
    out_t        pending[$];
    int          errors;

    function new();
      capacity = 64;
      occupied = 0;
      errors = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function void touch(int idx);
      int old;
      old = rank_q[idx];
      foreach (valid_q[i]) if (valid_q[i] && rank_q[i] < old) rank_q[i]++;
      rank_q[idx] = 0;
      if (count_q[idx] != 16'hFFFF) count_q[idx]++;
    endfunction

    function void evict();
      int victim;
      int vr;
      victim = -1;
      foreach (valid_q[i]) begin
        if (!valid_q[i]) continue;
        if (victim < 0 || count_q[i] < count_q[victim] ||
            (count_q[i] == count_q[victim] && rank_q[i] > rank_q[victim]))
          victim = i;
      end
      if (victim < 0) return;
      vr = rank_q[victim];
      valid_q[victim] = 0;
      foreach (valid_q[i]) if (valid_q[i] && rank_q[i] > vr) rank_q[i]--;
      if (occupied > 0) occupied--;
    endfunction

    // Note an accepted input transfer and queue its expected result
    function void note_input(in_t it);
      int   hit;
      int   slot;
      int   lim;
      out_t res;
      hit = -1;
      res = '0;
      lim = (capacity > Cap) ? Cap : capacity;
      foreach (valid_q[i]) if (hit < 0 && valid_q[i] && key_q[i] == it.key) hit = i;
      res.found = (hit >= 0);
      if (it.command == CMD_GET) begin
        if (hit >= 0) begin
          touch(hit);
          res.read_value = data_q[hit];
        end
      end else if (hit >= 0) begin
        data_q[hit] = it.value;
        touch(hit);
      end else if (lim != 0) begin
        if (occupied >= lim) evict();
        slot = -1;
        foreach (valid_q[i]) if (slot < 0 && !valid_q[i]) slot = i;
        if (slot >= 0) begin
          foreach (valid_q[i]) if (valid_q[i]) rank_q[i]++;
          valid_q[slot] = 1;
          key_q[slot] = it.key;
          data_q[slot] = it.value;
          count_q[slot] = 16'd1;
          rank_q[slot] = 0;
          occupied++;
        end
      end
      pending.push_back(res);
    endfunction

    // Compare one output transfer against the oldest expectation
    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result found=%0b read_value=%0d", $time,
                 got.found, got.read_value);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.found !== exp_r.found) begin
        $display("%0t: found mismatch expected %0b actual %0b", $time,
                 exp_r.found, got.found);
        errors++;
      end
      if (got.read_value !== exp_r.read_value) begin
        $display("%0t: read_value mismatch expected %0d actual %0d", $time,
                 exp_r.read_value, got.read_value);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_stall_o;
  in_t        in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 0;
  out_t       out_data_o;
  logic       cfg_we_i = 0;
  logic [6:0] cfg_wdata_i = '0;

  lfu_scoreboard sb = new();
  int          cycles = 0;
  bit          stall_hold = 0;
  logic [31:0] key_pool[16];

  lfu_cache_table #(.CAPACITY(Cap)) DUT (.*);

  always #5 clk_i = ~clk_i;

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stalls in random runs, with quiet stretches; check transfers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (stall_hold) out_stall_i <= 0;
    else if ((cycles / 2000) % 3 == 1) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= 0;
  end

  // Drive one transfer and hold it until accepted
  task automatic send_item(logic cmd, logic [31:0] k, logic [31:0] v);
    in_t it;
    it.command = cmd;
    it.key = k;
    it.value = v;
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Cap + 8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [6:0] c);
    cfg_we_i <= 1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.capacity = int'(c);
  endtask

  task automatic random_phase(int n, int nkeys);
    int sent;
    int burst;
    logic [31:0] k;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(0, nkeys - 1)];
        send_item(1'($urandom_range(0, 1)), k, $urandom());
        sent++;
      end
      if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 80));
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: extremes, miss, hit, update, eviction
    send_item(CMD_GET, 32'h0, 32'h0);
    send_item(CMD_PUT, 32'h0, 32'h8000_0000);
    send_item(CMD_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(CMD_GET, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_GET, 32'h0, 32'h0);
    drain();
    set_capacity(7'd2);
    send_item(CMD_PUT, 32'h10, 32'h1);  // evicts least used
    send_item(CMD_PUT, 32'h11, 32'h2);
    send_item(CMD_GET, 32'h10, 32'h0);
    send_item(CMD_PUT, 32'h12, 32'h3);  // evicts least used
    send_item(CMD_GET, 32'h11, 32'h0);
    send_item(CMD_GET, 32'h12, 32'h0);
    drain();
    set_capacity(7'd0);
    send_item(CMD_PUT, 32'h55, 32'h5);  // ignored
    send_item(CMD_PUT, 32'h12, 32'h9);  // update of present key
    send_item(CMD_GET, 32'h55, 32'h0);
    send_item(CMD_GET, 32'h12, 32'h0);
    drain();
    set_capacity(7'd127);               // clamps to the table size

    // Full-size table with a wide key pool
    random_phase(300, 16);
    drain();
    set_capacity(7'd3);
    random_phase(300, 8);
    // Hold the sender until every result is back
    drain();
    set_capacity(7'd1);
    random_phase(150, 4);
    drain();
    set_capacity(7'd64);
    stall_hold = 1;
    random_phase(150, 16);
    stall_hold = 0;
    random_phase(180, 16);

    drain();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
